FILE: design/css_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and helpers for the capacitance sensor sequencer
package css_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int IDX_W      = 6;
    localparam int LIM_W      = 12;
    localparam int WAKE_W     = 4;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    typedef struct packed {
        logic              store;
        logic              clr_index;
        logic [IDX_W-1:0]  target;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              load_sample;
        logic              load_status;
        logic              reset_line;
        logic              clock_line;
        logic              regulator_on;
        logic              isolation_on;
        logic              sleep_request;
        logic [WAKE_W-1:0] wake_after;
        logic              timeout_failure;
    } t_css_cmd;

    typedef struct packed {
        logic out_free;
        logic set_done;
    } t_css_stat;

    function automatic logic [SAMPLE_W-1:0] repack(input logic [SAMPLE_W-1:0] w);
        repack = {5'b0, w[31:5]} | {3'b0, w[1], 28'b0} | {5'b0, w[4:2], 24'b0};
    endfunction

endpackage

FILE: design/css_dp.sv
`timescale 1ns / 1ps
// sample store, sample index and output register of the sensor sequencer
module css_dp #(
    parameter int MAX_SAMPLES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  css_pkg::t_css_cmd              i_cmd,
    output css_pkg::t_css_stat             o_stat,
    input  logic [css_pkg::SAMPLE_W-1:0]   i_sensor_word,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic                           o_item_kind,
    output logic                           o_reset_line,
    output logic                           o_clock_line,
    output logic                           o_regulator_on,
    output logic                           o_isolation_on,
    output logic [css_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                           o_last_item,
    output logic                           o_sleep_request,
    output logic [css_pkg::WAKE_W-1:0]     o_wake_after,
    output logic                           o_timeout_failure
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    logic [css_pkg::SAMPLE_W-1:0] r_mem [MAX_SAMPLES];
    logic [css_pkg::SAMPLE_W-1:0] r_rdata;
    logic [css_pkg::IDX_W-1:0]    r_index;
    logic [css_pkg::IDX_W-1:0]    n_index;
    logic [css_pkg::IDX_W-1:0]    idx_inc;
    logic                         r_out_valid;

    assign idx_inc = (r_index != css_pkg::IDX_MAX) ? r_index + 1'b1 : r_index;

    assign o_stat.set_done = (idx_inc >= i_cmd.target);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_index = r_index;
        if (i_cmd.clr_index) begin
            n_index = '0;
        end else if (i_cmd.store) begin
            n_index = idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else begin
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_index < css_pkg::IDX_W'(MAX_SAMPLES))) begin
            r_mem[r_index[AW-1:0]] <= i_sensor_word;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_cmd.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_sample || i_cmd.load_status) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample || i_cmd.load_status) begin
            o_item_kind       <= i_cmd.load_sample;
            o_reset_line      <= i_cmd.reset_line;
            o_clock_line      <= i_cmd.clock_line;
            o_regulator_on    <= i_cmd.regulator_on;
            o_isolation_on    <= i_cmd.isolation_on;
            o_last_item       <= i_cmd.load_status;
            o_sample_out      <= i_cmd.load_sample ? css_pkg::repack(r_rdata) : '0;
            o_sleep_request   <= i_cmd.load_status & i_cmd.sleep_request;
            o_wake_after      <= i_cmd.load_status ? i_cmd.wake_after : '0;
            o_timeout_failure <= i_cmd.load_status & i_cmd.timeout_failure;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_no_double_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_sample && i_cmd.load_status))
        else $error("sample and status loaded together");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_sample || i_cmd.load_status) |-> o_stat.out_free)
        else $error("output register overwritten");

    a_clear_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_index |=> r_index == '0)
        else $error("sample index not cleared");
`endif

endmodule

FILE: design/css_ctrl.sv
`timescale 1ns / 1ps
// phase controller, wait counter, line levels and result sequencing
module css_ctrl #(
    parameter int MAX_SAMPLES = 32,
    parameter int WAIT_WIDTH  = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_opcode,
    input  logic                             i_word_ok,
    input  logic                             i_cfg_we,
    input  logic [css_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [css_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output css_pkg::t_css_cmd                o_cmd,
    input  css_pkg::t_css_stat               i_stat
);

    localparam int CW = (WAIT_WIDTH > css_pkg::LIM_W) ? WAIT_WIDTH : css_pkg::LIM_W;
    localparam logic [WAIT_WIDTH-1:0] WAIT_MAX = {WAIT_WIDTH{1'b1}};

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_RST   = 3'd1;
    localparam logic [2:0] PH_RWAIT = 3'd2;
    localparam logic [2:0] PH_MEAS  = 3'd3;
    localparam logic [2:0] PH_READ  = 3'd4;

    localparam logic [1:0] EM_NONE = 2'd0;
    localparam logic [1:0] EM_RD   = 2'd1;
    localparam logic [1:0] EM_LD   = 2'd2;
    localparam logic [1:0] EM_STAT = 2'd3;

    localparam logic [css_pkg::CFG_IDX_W-1:0] CFG_TARGET    = 3'd0;
    localparam logic [css_pkg::CFG_IDX_W-1:0] CFG_RST_LIM   = 3'd1;
    localparam logic [css_pkg::CFG_IDX_W-1:0] CFG_READ_LIM  = 3'd2;
    localparam logic [css_pkg::CFG_IDX_W-1:0] CFG_NORM_WAKE = 3'd3;
    localparam logic [css_pkg::CFG_IDX_W-1:0] CFG_FAIL_WAKE = 3'd4;

    logic [css_pkg::IDX_W-1:0]  r_target;
    logic [css_pkg::LIM_W-1:0]  r_rst_lim;
    logic [css_pkg::LIM_W-1:0]  r_read_lim;
    logic [css_pkg::WAKE_W-1:0] r_norm_wake;
    logic [css_pkg::WAKE_W-1:0] r_fail_wake;

    logic [2:0]                 r_phase, n_phase;
    logic                       r_retry, n_retry;
    logic [WAIT_WIDTH-1:0]      r_wait, n_wait;
    logic                       r_rst, n_rst;
    logic                       r_clk, n_clk;
    logic                       r_reg, n_reg;
    logic                       r_iso, n_iso;
    logic [1:0]                 r_emit, n_emit;
    logic [css_pkg::IDX_W-1:0]  r_k, n_k;
    logic                       r_pend_sleep, n_pend_sleep;
    logic [css_pkg::WAKE_W-1:0] r_pend_wake, n_pend_wake;

    logic                       in_acc;
    logic [css_pkg::IDX_W-1:0]  tgt;
    logic [WAIT_WIDTH-1:0]      w_inc;
    logic [css_pkg::LIM_W-1:0]  lim;
    logic                       timeout;
    logic                       sleep, fail;
    logic [css_pkg::WAKE_W-1:0] wake;
    logic                       store, clr_index, rd_en, load_sample, load_status;

    assign o_in_stall = (r_emit != EM_NONE) || !i_stat.out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign tgt = (r_target == '0) ? css_pkg::IDX_W'(1) :
                 (r_target > css_pkg::IDX_W'(MAX_SAMPLES)) ? css_pkg::IDX_W'(MAX_SAMPLES) :
                 r_target;

    assign lim     = (r_phase == PH_READ) ? r_read_lim : r_rst_lim;
    assign w_inc   = (r_wait != WAIT_MAX) ? r_wait + 1'b1 : r_wait;
    assign timeout = (CW'(w_inc) >= CW'(lim)) || (w_inc == WAIT_MAX);

    always_comb begin
        n_phase      = r_phase;
        n_retry      = r_retry;
        n_wait       = r_wait;
        n_rst        = r_rst;
        n_clk        = r_clk;
        n_reg        = r_reg;
        n_iso        = r_iso;
        n_emit       = r_emit;
        n_k          = r_k;
        n_pend_sleep = r_pend_sleep;
        n_pend_wake  = r_pend_wake;
        sleep        = 1'b0;
        wake         = '0;
        fail         = 1'b0;
        store        = 1'b0;
        clr_index    = 1'b0;
        rd_en        = 1'b0;
        load_sample  = 1'b0;
        load_status  = 1'b0;
        case (r_emit)
            EM_NONE: begin
                if (in_acc) begin
                    case (r_phase)
                        PH_IDLE: begin
                            n_reg   = 1'b1;
                            n_iso   = 1'b0;
                            n_retry = 1'b0;
                            n_phase = PH_RST;
                        end
                        PH_RST: begin
                            n_rst   = 1'b0;
                            n_clk   = 1'b0;
                            n_wait  = '0;
                            n_phase = PH_RWAIT;
                        end
                        PH_RWAIT: begin
                            if (i_opcode) begin
                                n_phase = PH_MEAS;
                            end else begin
                                n_wait = w_inc;
                                if (timeout) begin
                                    n_wait = '0;
                                    if (r_retry) begin
                                        fail    = 1'b1;
                                        sleep   = 1'b1;
                                        wake    = r_fail_wake;
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_retry = 1'b1;
                                        n_rst   = 1'b1;
                                        n_clk   = 1'b0;
                                        n_phase = PH_RST;
                                    end
                                end
                            end
                        end
                        PH_MEAS: begin
                            n_rst   = 1'b0;
                            n_clk   = 1'b1;
                            n_wait  = '0;
                            n_phase = PH_READ;
                        end
                        PH_READ: begin
                            if (!i_opcode) begin
                                n_wait = w_inc;
                                if (timeout) begin
                                    n_wait  = '0;
                                    n_clk   = 1'b0;
                                    n_rst   = 1'b1;
                                    n_phase = PH_RST;
                                end
                            end else if (!i_word_ok) begin
                                n_clk   = 1'b0;
                                n_rst   = 1'b1;
                                n_phase = PH_RST;
                            end else begin
                                store = 1'b1;
                                if (i_stat.set_done) begin
                                    clr_index    = 1'b1;
                                    n_rst        = 1'b0;
                                    n_clk        = 1'b0;
                                    n_iso        = 1'b1;
                                    n_reg        = 1'b0;
                                    n_phase      = PH_IDLE;
                                    n_pend_sleep = 1'b1;
                                    n_pend_wake  = r_norm_wake;
                                    n_k          = '0;
                                    n_emit       = EM_RD;
                                end else begin
                                    n_clk   = 1'b0;
                                    n_rst   = 1'b1;
                                    n_phase = PH_RST;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_rst   = 1'b1;
                            n_clk   = 1'b0;
                            sleep   = 1'b1;
                            wake    = r_norm_wake;
                        end
                    endcase
                    load_status = (n_emit == EM_NONE);
                end
            end
            EM_RD: begin
                rd_en  = 1'b1;
                n_emit = EM_LD;
            end
            EM_LD: begin
                if (i_stat.out_free) begin
                    load_sample = 1'b1;
                    if (r_k + 1'b1 == tgt) begin
                        n_emit = EM_STAT;
                    end else begin
                        n_k    = r_k + 1'b1;
                        n_emit = EM_RD;
                    end
                end
            end
            EM_STAT: begin
                if (i_stat.out_free) begin
                    load_status = 1'b1;
                    sleep       = r_pend_sleep;
                    wake        = r_pend_wake;
                    n_emit      = EM_NONE;
                end
            end
            default: begin
                n_emit = EM_NONE;
            end
        endcase
    end

    always_comb begin
        o_cmd.store           = store;
        o_cmd.clr_index       = clr_index;
        o_cmd.target          = tgt;
        o_cmd.rd_en           = rd_en;
        o_cmd.rd_addr         = r_k;
        o_cmd.load_sample     = load_sample;
        o_cmd.load_status     = load_status;
        o_cmd.reset_line      = n_rst;
        o_cmd.clock_line      = n_clk;
        o_cmd.regulator_on    = n_reg;
        o_cmd.isolation_on    = n_iso;
        o_cmd.sleep_request   = sleep;
        o_cmd.wake_after      = wake;
        o_cmd.timeout_failure = fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_retry <= 1'b0;
            r_wait  <= '0;
            r_rst   <= 1'b1;
            r_clk   <= 1'b0;
            r_reg   <= 1'b0;
            r_iso   <= 1'b1;
            r_emit  <= EM_NONE;
        end else begin
            r_phase <= n_phase;
            r_retry <= n_retry;
            r_wait  <= n_wait;
            r_rst   <= n_rst;
            r_clk   <= n_clk;
            r_reg   <= n_reg;
            r_iso   <= n_iso;
            r_emit  <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_pend_sleep <= n_pend_sleep;
        r_pend_wake  <= n_pend_wake;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= css_pkg::IDX_W'(20);
            r_rst_lim   <= css_pkg::LIM_W'(2000);
            r_read_lim  <= css_pkg::LIM_W'(1000);
            r_norm_wake <= css_pkg::WAKE_W'(3);
            r_fail_wake <= css_pkg::WAKE_W'(5);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET:    r_target    <= i_cfg_data[css_pkg::IDX_W-1:0];
                CFG_RST_LIM:   r_rst_lim   <= i_cfg_data[css_pkg::LIM_W-1:0];
                CFG_READ_LIM:  r_read_lim  <= i_cfg_data[css_pkg::LIM_W-1:0];
                CFG_NORM_WAKE: r_norm_wake <= i_cfg_data[css_pkg::WAKE_W-1:0];
                CFG_FAIL_WAKE: r_fail_wake <= i_cfg_data[css_pkg::WAKE_W-1:0];
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_dump_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_READ && i_opcode && i_word_ok && i_stat.set_done)
        |=> (r_emit == EM_RD))
        else $error("completed set did not start the dump");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit == EM_RD) |=> (r_emit == EM_LD))
        else $error("store read not followed by load");

    a_status_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit == EM_STAT && i_stat.out_free) |-> (load_status && sleep))
        else $error("dump closed without status request");
`endif

endmodule

FILE: design/capacitance_sensor_sequencer.sv
`timescale 1ns / 1ps
// top level of the capacitance sensor sequencer
//
//   channel  direction  handshake                    payload
//   in       request    i_in_valid / o_in_stall      i_opcode, i_sensor_word
//   out      result     o_out_valid / i_out_stall    o_item_kind .. o_timeout_failure
//   cfg      write      i_cfg_we                     i_cfg_index, i_cfg_data
//
// a request that does not complete a sample set loads only a status item; that item
// sits in the output register the next cycle and the next request may enter then
// a request that completes a set emits target samples through the store read
// register and the output register in turn, then the status item, with input
// stalled throughout; a stalled output register holds off input; reset is
// synchronous, active low
module capacitance_sensor_sequencer #(
    parameter int MAX_SAMPLES = 32,
    parameter int WAIT_WIDTH  = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_opcode,
    input  logic [css_pkg::SAMPLE_W-1:0]     i_sensor_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_item_kind,
    output logic                             o_reset_line,
    output logic                             o_clock_line,
    output logic                             o_regulator_on,
    output logic                             o_isolation_on,
    output logic [css_pkg::SAMPLE_W-1:0]     o_sample_out,
    output logic                             o_last_item,
    output logic                             o_sleep_request,
    output logic [css_pkg::WAKE_W-1:0]       o_wake_after,
    output logic                             o_timeout_failure,
    input  logic                             i_cfg_we,
    input  logic [css_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [css_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    css_pkg::t_css_cmd  cmd;
    css_pkg::t_css_stat stat;

    css_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .WAIT_WIDTH  (WAIT_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_word_ok   (i_sensor_word[1]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    css_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_sensor_word     (i_sensor_word),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_item_kind       (o_item_kind),
        .o_reset_line      (o_reset_line),
        .o_clock_line      (o_clock_line),
        .o_regulator_on    (o_regulator_on),
        .o_isolation_on    (o_isolation_on),
        .o_sample_out      (o_sample_out),
        .o_last_item       (o_last_item),
        .o_sleep_request   (o_sleep_request),
        .o_wake_after      (o_wake_after),
        .o_timeout_failure (o_timeout_failure)
    );

endmodule

FILE: dv/css_checker.sv
`timescale 1ns / 1ps
// stimulus codes and the result checker for the capacitance sensor sequencer
package css_tb_pkg;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_MSG  = 1'b1
    } t_opcode;

    localparam logic [css_pkg::CFG_IDX_W-1:0] REG_SAMPLE_TARGET  = 3'd0;
    localparam logic [css_pkg::CFG_IDX_W-1:0] REG_RESET_WAIT_LIM = 3'd1;
    localparam logic [css_pkg::CFG_IDX_W-1:0] REG_READ_WAIT_LIM  = 3'd2;
    localparam logic [css_pkg::CFG_IDX_W-1:0] REG_NORMAL_WAKE    = 3'd3;
    localparam logic [css_pkg::CFG_IDX_W-1:0] REG_FAILURE_WAKE   = 3'd4;
    localparam logic [css_pkg::CFG_IDX_W-1:0] REG_UNUSED         = 3'd7;

endpackage

module css_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_opcode,
    input  logic [css_pkg::SAMPLE_W-1:0]    i_sensor_word,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_item_kind,
    input  logic                            i_reset_line,
    input  logic                            i_clock_line,
    input  logic                            i_regulator_on,
    input  logic                            i_isolation_on,
    input  logic [css_pkg::SAMPLE_W-1:0]    i_sample_out,
    input  logic                            i_last_item,
    input  logic                            i_sleep_request,
    input  logic [css_pkg::WAKE_W-1:0]      i_wake_after,
    input  logic                            i_timeout_failure,
    input  logic                            i_cfg_we,
    input  logic [css_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [css_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int STORE_DEPTH = 32;
    localparam int SW          = $clog2(STORE_DEPTH);
    localparam int TW          = css_pkg::IDX_W + 1;
    localparam int DW          = css_pkg::SAMPLE_W;
    localparam logic [css_pkg::LIM_W-1:0] WAIT_SAT = '1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESET_ASSERTED,
        PH_RESET_WAIT,
        PH_MEASURE,
        PH_READ_WAIT
    } t_phase;

    typedef struct packed {
        logic                         kind;
        logic                         reset_line;
        logic                         clock_line;
        logic                         regulator_on;
        logic                         isolation_on;
        logic [css_pkg::SAMPLE_W-1:0] sample;
        logic                         last;
        logic                         sleep;
        logic [css_pkg::WAKE_W-1:0]   wake;
        logic                         fail;
    } t_seq_item;

    logic [css_pkg::IDX_W-1:0]    cfg_target;
    logic [css_pkg::LIM_W-1:0]    cfg_reset_limit;
    logic [css_pkg::LIM_W-1:0]    cfg_read_limit;
    logic [css_pkg::WAKE_W-1:0]   cfg_normal_wake;
    logic [css_pkg::WAKE_W-1:0]   cfg_fail_wake;

    t_phase                       phase;
    logic                         retry_used;
    logic [css_pkg::LIM_W-1:0]    wait_ticks;
    logic [css_pkg::IDX_W-1:0]    sample_index;
    logic [css_pkg::SAMPLE_W-1:0] sample_store [STORE_DEPTH];
    logic                         lvl_reset;
    logic                         lvl_clock;
    logic                         lvl_regulator;
    logic                         lvl_isolation;

    t_seq_item                    items_due [$];

    task automatic count_wait(input logic [css_pkg::LIM_W-1:0] limit, output logic expired);
        if (wait_ticks != WAIT_SAT) wait_ticks++;
        expired = (wait_ticks >= limit) || (wait_ticks == WAIT_SAT);
    endtask

    task automatic restart_measure();
        lvl_clock = 1'b0;
        lvl_reset = 1'b1;
        phase     = PH_RESET_ASSERTED;
    endtask

    task automatic queue_item(input logic kind, input logic [css_pkg::SAMPLE_W-1:0] sample,
                              input logic last, input logic sleep,
                              input logic [css_pkg::WAKE_W-1:0] wake, input logic fail);
        t_seq_item it;
        it.kind         = kind;
        it.reset_line   = lvl_reset;
        it.clock_line   = lvl_clock;
        it.regulator_on = lvl_regulator;
        it.isolation_on = lvl_isolation;
        it.sample       = sample;
        it.last         = last;
        it.sleep        = sleep;
        it.wake         = wake;
        it.fail         = fail;
        items_due.push_back(it);
    endtask

    task automatic advance_sequencer(input logic is_msg,
                                     input logic [css_pkg::SAMPLE_W-1:0] word);
        logic                         sleep;
        logic                         fail;
        logic                         expired;
        logic [css_pkg::WAKE_W-1:0]   wake;
        logic [TW-1:0]                target;
        logic [css_pkg::SAMPLE_W-1:0] w;
        int                           dump;
        int                           i;
        sleep = 1'b0;
        fail  = 1'b0;
        wake  = '0;
        dump  = 0;
        case (phase)
            PH_IDLE: begin
                lvl_regulator = 1'b1;
                lvl_isolation = 1'b0;
                retry_used    = 1'b0;
                phase         = PH_RESET_ASSERTED;
            end
            PH_RESET_ASSERTED: begin
                lvl_reset  = 1'b0;
                lvl_clock  = 1'b0;
                wait_ticks = '0;
                phase      = PH_RESET_WAIT;
            end
            PH_RESET_WAIT: begin
                if (is_msg) begin
                    phase = PH_MEASURE;
                end else begin
                    count_wait(cfg_reset_limit, expired);
                    if (expired) begin
                        wait_ticks = '0;
                        if (retry_used) begin
                            fail  = 1'b1;
                            sleep = 1'b1;
                            wake  = cfg_fail_wake;
                            phase = PH_IDLE;
                        end else begin
                            retry_used = 1'b1;
                            lvl_reset  = 1'b1;
                            lvl_clock  = 1'b0;
                            phase      = PH_RESET_ASSERTED;
                        end
                    end
                end
            end
            PH_MEASURE: begin
                lvl_reset  = 1'b0;
                lvl_clock  = 1'b1;
                wait_ticks = '0;
                phase      = PH_READ_WAIT;
            end
            PH_READ_WAIT: begin
                if (!is_msg) begin
                    count_wait(cfg_read_limit, expired);
                    if (expired) begin
                        wait_ticks = '0;
                        restart_measure();
                    end
                end else if (!word[1]) begin
                    restart_measure();
                end else begin
                    target = {1'b0, cfg_target};
                    if (target == '0) target = TW'(1);
                    if (target > TW'(STORE_DEPTH)) target = TW'(STORE_DEPTH);
                    if (sample_index < css_pkg::IDX_W'(STORE_DEPTH)) begin
                        sample_store[sample_index[SW-1:0]] = word;
                    end
                    if (sample_index != css_pkg::IDX_MAX) sample_index++;
                    if ({1'b0, sample_index} >= target) begin
                        dump          = int'(target);
                        sample_index  = '0;
                        lvl_reset     = 1'b0;
                        lvl_clock     = 1'b0;
                        lvl_isolation = 1'b1;
                        lvl_regulator = 1'b0;
                        sleep         = 1'b1;
                        wake          = cfg_normal_wake;
                        phase         = PH_IDLE;
                    end else begin
                        restart_measure();
                    end
                end
            end
            default: begin
                phase     = PH_IDLE;
                lvl_reset = 1'b1;
                lvl_clock = 1'b0;
                sleep     = 1'b1;
                wake      = cfg_normal_wake;
            end
        endcase
        // range bits land on top of code bits 26:24
        for (i = 0; i < dump; i++) begin
            w = sample_store[i];
            queue_item(1'b1, (w >> 5) | (DW'(w[1]) << 28) | (DW'(w[4:2]) << 24),
                       1'b0, 1'b0, '0, 1'b0);
        end
        queue_item(1'b0, '0, 1'b1, sleep, wake, fail);
    endtask

    task automatic check_field(input string name, input logic [css_pkg::SAMPLE_W-1:0] want,
                               input logic [css_pkg::SAMPLE_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_seq_item want;
        if (!i_rst_n) begin
            cfg_target      = 6'd20;
            cfg_reset_limit = 12'd2000;
            cfg_read_limit  = 12'd1000;
            cfg_normal_wake = 4'd3;
            cfg_fail_wake   = 4'd5;
            phase           = PH_IDLE;
            retry_used      = 1'b0;
            wait_ticks      = '0;
            sample_index    = '0;
            lvl_reset       = 1'b1;
            lvl_clock       = 1'b0;
            lvl_regulator   = 1'b0;
            lvl_isolation   = 1'b1;
            o_fail_count    = 0;
            items_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    css_tb_pkg::REG_SAMPLE_TARGET:
                        cfg_target      = i_cfg_data[css_pkg::IDX_W-1:0];
                    css_tb_pkg::REG_RESET_WAIT_LIM:
                        cfg_reset_limit = i_cfg_data[css_pkg::LIM_W-1:0];
                    css_tb_pkg::REG_READ_WAIT_LIM:
                        cfg_read_limit  = i_cfg_data[css_pkg::LIM_W-1:0];
                    css_tb_pkg::REG_NORMAL_WAKE:
                        cfg_normal_wake = i_cfg_data[css_pkg::WAKE_W-1:0];
                    css_tb_pkg::REG_FAILURE_WAKE:
                        cfg_fail_wake   = i_cfg_data[css_pkg::WAKE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (items_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result mismatch, expected none actual kind %0d sample %h",
                             $time, i_item_kind, i_sample_out);
                end else begin
                    want = items_due.pop_front();
                    check_field("item_kind", DW'(want.kind), DW'(i_item_kind));
                    check_field("reset_line", DW'(want.reset_line), DW'(i_reset_line));
                    check_field("clock_line", DW'(want.clock_line), DW'(i_clock_line));
                    check_field("regulator_on", DW'(want.regulator_on),
                                DW'(i_regulator_on));
                    check_field("isolation_on", DW'(want.isolation_on),
                                DW'(i_isolation_on));
                    check_field("sample_out", want.sample, i_sample_out);
                    check_field("last_item", DW'(want.last), DW'(i_last_item));
                    check_field("sleep_request", DW'(want.sleep), DW'(i_sleep_request));
                    check_field("wake_after", DW'(want.wake), DW'(i_wake_after));
                    check_field("timeout_failure", DW'(want.fail), DW'(i_timeout_failure));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_sequencer(i_opcode == css_tb_pkg::OP_MSG, i_sensor_word);
            end
        end
        o_pending = items_due.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// top of the capacitance sensor sequencer testbench: clock, reset, requests and verdict
module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 70;
    localparam int CW           = css_pkg::CFG_DATA_W;
    localparam logic [css_pkg::SAMPLE_W-1:0] WORD_VALID = 32'h2;

    logic                           clk;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_opcode   = 1'b0;
    logic [css_pkg::SAMPLE_W-1:0]   in_word     = '0;
    logic                           out_stall   = 1'b0;
    logic                           cfg_we      = 1'b0;
    logic [css_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [css_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

    logic                           in_stall;
    logic                           out_valid;
    logic                           item_kind;
    logic                           reset_line;
    logic                           clock_line;
    logic                           regulator_on;
    logic                           isolation_on;
    logic [css_pkg::SAMPLE_W-1:0]   sample_out;
    logic                           last_item;
    logic                           sleep_request;
    logic [css_pkg::WAKE_W-1:0]     wake_after;
    logic                           timeout_failure;

    int fail_count;
    int pending;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    capacitance_sensor_sequencer u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_opcode          (in_opcode),
        .i_sensor_word     (in_word),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_item_kind       (item_kind),
        .o_reset_line      (reset_line),
        .o_clock_line      (clock_line),
        .o_regulator_on    (regulator_on),
        .o_isolation_on    (isolation_on),
        .o_sample_out      (sample_out),
        .o_last_item       (last_item),
        .o_sleep_request   (sleep_request),
        .o_wake_after      (wake_after),
        .o_timeout_failure (timeout_failure),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    css_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_opcode          (in_opcode),
        .i_sensor_word     (in_word),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_item_kind       (item_kind),
        .i_reset_line      (reset_line),
        .i_clock_line      (clock_line),
        .i_regulator_on    (regulator_on),
        .i_isolation_on    (isolation_on),
        .i_sample_out      (sample_out),
        .i_last_item       (last_item),
        .i_sleep_request   (sleep_request),
        .i_wake_after      (wake_after),
        .i_timeout_failure (timeout_failure),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // result side back-pressure, with a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left == 0 && hold_asks != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_request(input css_tb_pkg::t_opcode op,
                                input logic [css_pkg::SAMPLE_W-1:0] word);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_word   <= word;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [css_pkg::CFG_IDX_W-1:0] idx,
                             input logic [css_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_registers(input int target, input int reset_lim, input int read_lim,
                                 input int normal_wake, input int fail_wake);
        write_reg(css_tb_pkg::REG_SAMPLE_TARGET, CW'(target));
        write_reg(css_tb_pkg::REG_RESET_WAIT_LIM, CW'(reset_lim));
        write_reg(css_tb_pkg::REG_READ_WAIT_LIM, CW'(read_lim));
        write_reg(css_tb_pkg::REG_NORMAL_WAKE, CW'(normal_wake));
        write_reg(css_tb_pkg::REG_FAILURE_WAKE, CW'(fail_wake));
        cfg_we <= 1'b0;
    endtask

    // mostly valid words, mixed with ticks and invalid words at the given percentages
    task automatic send_random(input int count, input int tick_pct, input int bad_pct);
        int                           k;
        int                           r;
        logic [css_pkg::SAMPLE_W-1:0] w;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(99);
            w = $urandom;
            if (r < tick_pct) send_request(css_tb_pkg::OP_TICK, w);
            else if (r < tick_pct + bad_pct) send_request(css_tb_pkg::OP_MSG, w & ~WORD_VALID);
            else send_request(css_tb_pkg::OP_MSG, w | WORD_VALID);
        end
    endtask

    task automatic send_opening();
        logic [css_pkg::SAMPLE_W-1:0] samples [4] = '{32'hFFFF_FFFF, 32'h0000_0002,
                                                      32'hAAAA_AAAA, 32'h0000_001E};
        int                           k;
        send_request(css_tb_pkg::OP_MSG, 32'hFFFF_FFFF);
        send_request(css_tb_pkg::OP_TICK, 32'h0000_0000);
        send_request(css_tb_pkg::OP_TICK, 32'hFFFF_FFFF);
        send_request(css_tb_pkg::OP_MSG, 32'h0000_0000);
        send_request(css_tb_pkg::OP_MSG, 32'hFFFF_FFFF);
        send_request(css_tb_pkg::OP_TICK, 32'h0000_0000);
        send_request(css_tb_pkg::OP_MSG, 32'hFFFF_FFFD);
        for (k = 0; k < 4; k++) begin
            send_request(css_tb_pkg::OP_TICK, 32'h0000_0000);
            send_request(css_tb_pkg::OP_MSG, 32'h0000_0000);
            send_request(css_tb_pkg::OP_TICK, 32'hFFFF_FFFF);
            send_request(css_tb_pkg::OP_MSG, samples[k]);
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 8;
        recv_idle_pct = 54;
        send_opening();
        send_random(40, 20, 8);

        wait_drained();
        set_registers(0, 0, 0, 0, 15);
        send_random(50, 30, 10);

        wait_drained();
        set_registers(63, 4095, 4095, 15, 0);
        hold_asks++;
        send_random(90, 8, 4);

        send_idle_pct = 54;
        recv_idle_pct = 8;
        wait_drained();
        set_registers(1, 1, 2, 7, 9);
        send_random(30, 25, 8);
        wait_drained();
        send_random(30, 25, 8);

        wait_drained();
        write_reg(css_tb_pkg::REG_UNUSED, CW'($urandom));
        set_registers(2, 4, 1, 12, 3);
        send_random(50, 20, 8);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        set_registers(32, 2, 3, 10, 6);
        send_random(60, 10, 5);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
